// ===== rtl/sspi_pkg.sv =====
// ============================================================================
// sspi_pkg - speech synthesizer parameter interface definitions
// Item codes, status bit positions, frame geometry and the item/result types
// shared by the interfaces, the core and the top level.
// ============================================================================
`default_nettype none

package sspi_pkg;

  // Item codes on the command field
  localparam logic [2:0] CMD_DATA   = 3'd0;
  localparam logic [2:0] CMD_MODE   = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_STATUS = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  // Command port bytes
  localparam logic [7:0] OP_START       = 8'hFE;
  localparam logic [7:0] OP_STOP        = 8'hFF;
  localparam logic [7:0] OP_PHRASE_LAST = 8'h04;

  // Status bit positions
  localparam int unsigned ST_BUSY = 7;
  localparam int unsigned ST_REQ  = 6;
  localparam int unsigned ST_EXT  = 5;
  localparam int unsigned ST_ERR  = 4;

  localparam logic [7:0] STATUS_RUN = 8'hE0;  // busy, request, external
  localparam logic [7:0] STATUS_ERR = 8'h10;  // error only

  // Frame geometry
  localparam int unsigned FRAME_BYTES = 7;
  localparam int unsigned INDEX_W     = $clog2(FRAME_BYTES);
  localparam int unsigned FRAME_W     = 8 * FRAME_BYTES;
  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0]         status;
    logic               interrupt_request;
    logic               frame_valid;
    logic [FRAME_W-1:0] frame_params;
    logic               mode_valid;
    logic [7:0]         mode_value;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/sspi_in_if.sv =====
// ============================================================================
// sspi_in_if - host item channel
// Valid/ready channel carrying one host access or frame tick.
// ============================================================================
`default_nettype none

interface sspi_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/sspi_out_if.sv =====
// ============================================================================
// sspi_out_if - result channel
// Valid/ready channel carrying status, interrupt, frame and mode outputs.
// ============================================================================
`default_nettype none

interface sspi_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    status;
  logic                          interrupt_request;
  logic                          frame_valid;
  logic [sspi_pkg::FRAME_W-1:0]  frame_params;
  logic                          mode_valid;
  logic [7:0]                    mode_value;

  modport source (output valid, status, interrupt_request, frame_valid, frame_params,
                  mode_valid, mode_value, input ready);
  modport sink   (input valid, status, interrupt_request, frame_valid, frame_params,
                  mode_valid, mode_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/sspi_core.sv =====
// ============================================================================
// sspi_core - interface state and per-item update
// Holds status, frame store and collection counters; computes the result of
// one item and commits the new state when step is high.
// ============================================================================
`default_nettype none

module sspi_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire sspi_pkg::item_t   item,
  output sspi_pkg::result_t      result
);

  logic [7:0]                     status_reg, status_next;
  logic [7:0]                     param_store [sspi_pkg::FRAME_BYTES];
  logic [7:0]                     store_next  [sspi_pkg::FRAME_BYTES];
  logic [sspi_pkg::INDEX_W-1:0]   param_index, index_next;
  logic [4:0]                     repeat_count, repeat_next;
  logic                           params_ready, ready_next;
  logic                           frames_running, running_next;
  logic                           irq;
  logic                           halt;
  logic [sspi_pkg::FRAME_W-1:0]   packed_frame;

  always_comb begin
    for (int i = 0; i < sspi_pkg::FRAME_BYTES; i++) begin
      packed_frame[8*i +: 8] = param_store[i];
    end
  end

  always_comb begin
    status_next  = status_reg;
    store_next   = param_store;
    index_next   = param_index;
    repeat_next  = repeat_count;
    ready_next   = params_ready;
    running_next = frames_running;
    irq          = 1'b0;
    halt         = 1'b0;
    result       = '0;

    unique case (item.command)
      sspi_pkg::CMD_DATA: begin
        if (status_reg[sspi_pkg::ST_BUSY] && status_reg[sspi_pkg::ST_REQ]) begin
          if (repeat_count == 5'd0 || param_index != '0) begin
            if (param_index == '0) begin
              repeat_next = item.value[7:3];
            end
            store_next[param_index] = item.value;
            if (param_index == sspi_pkg::LAST_INDEX) begin
              status_next[sspi_pkg::ST_REQ] = 1'b0;
              index_next = '0;
              if (repeat_count != 5'd0) begin
                repeat_next = repeat_count - 5'd1;
              end
              ready_next = 1'b1;
            end else begin
              index_next = param_index + 1'b1;
              irq        = 1'b1;
            end
          end else begin
            // repeat frame: one byte, middle bytes zeroed, byte 0 kept
            for (int i = 1; i < sspi_pkg::FRAME_BYTES - 1; i++) begin
              store_next[i] = 8'h00;
            end
            store_next[sspi_pkg::FRAME_BYTES-1] = item.value;
            status_next[sspi_pkg::ST_REQ] = 1'b0;
            index_next  = '0;
            repeat_next = repeat_count - 5'd1;
            ready_next  = 1'b1;
          end
        end
      end
      sspi_pkg::CMD_MODE: begin
        result.mode_valid = 1'b1;
        result.mode_value = item.value;
        status_next       = 8'h00;
      end
      sspi_pkg::CMD_WRITE: begin
        halt = 1'b1;
        if (item.value == sspi_pkg::OP_START) begin
          running_next = 1'b1;
          status_next  = sspi_pkg::STATUS_RUN;
          irq          = 1'b1;
        end else if (item.value == sspi_pkg::OP_STOP ||
                     item.value <= sspi_pkg::OP_PHRASE_LAST) begin
          status_next[sspi_pkg::ST_BUSY] = 1'b0;
        end else begin
          status_next = sspi_pkg::STATUS_ERR;
        end
      end
      sspi_pkg::CMD_TICK: begin
        if (frames_running) begin
          if (!status_reg[sspi_pkg::ST_EXT]) begin
            halt = 1'b1;
            status_next[sspi_pkg::ST_BUSY] = 1'b0;
          end else if (!params_ready) begin
            halt        = 1'b1;
            status_next = sspi_pkg::STATUS_ERR;
          end else if (param_store[0][7:3] == 5'd0) begin
            halt = 1'b1;
            status_next[sspi_pkg::ST_BUSY] = 1'b0;
          end else begin
            result.frame_valid  = 1'b1;
            result.frame_params = packed_frame;
            ready_next          = 1'b0;
            status_next[sspi_pkg::ST_REQ] = 1'b1;
            irq                 = 1'b1;
          end
        end
      end
      default: begin
        // status read and unused codes: report only
      end
    endcase

    // stop: busy bit is handled in each arm above
    if (halt && !(item.command == sspi_pkg::CMD_WRITE && item.value == sspi_pkg::OP_START))
    begin
      running_next = 1'b0;
    end
    if (halt) begin
      index_next  = '0;
      repeat_next = 5'd0;
      ready_next  = 1'b0;
    end

    result.status            = status_next;
    result.interrupt_request = irq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg     <= 8'h00;
      param_index    <= '0;
      repeat_count   <= 5'd0;
      params_ready   <= 1'b0;
      frames_running <= 1'b0;
      for (int i = 0; i < sspi_pkg::FRAME_BYTES; i++) begin
        param_store[i] <= 8'h00;
      end
    end else if (step) begin
      status_reg     <= status_next;
      param_index    <= index_next;
      repeat_count   <= repeat_next;
      params_ready   <= ready_next;
      frames_running <= running_next;
      param_store    <= store_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/speech_synth_parameter_interface_top.sv =====
// ============================================================================
// speech_synth_parameter_interface_top - speech synthesizer host interface
// Takes host data/mode/command writes, status reads and frame ticks; returns
// status, parameter-request interrupt, parameter frames and mode strobes.
// ============================================================================
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+-------------
//   req     | in  | command[2:0], value[7:0]                  | valid/ready
//   rsp     | out | status, interrupt_request, frame_valid,   | valid/ready
//           |     | frame_params[55:0], mode_valid, mode_value|
//
// One item per cycle while the rsp register is free. The core updates its state in
// the cycle an item is accepted and the result lands in the rsp register on the
// same edge, so it shows in the cycle after acceptance. req.ready stays high while
// rsp is empty or being taken, so a stalled sink stalls the source after one item only.
// Synchronous reset clears status, frame store and collection counters.
// ============================================================================
`default_nettype none

module speech_synth_parameter_interface_top (
  input  wire logic  clk,
  input  wire logic  rst,
  sspi_in_if.sink    req,
  sspi_out_if.source rsp
);

  logic              accept;
  sspi_pkg::item_t   item;
  sspi_pkg::result_t result;
  sspi_pkg::result_t rsp_data;
  logic              rsp_valid;

  // input side frees up whenever the result register drains this cycle
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign item.command = req.command;
  assign item.value   = req.value;

  sspi_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.status            = rsp_data.status;
  assign rsp.interrupt_request = rsp_data.interrupt_request;
  assign rsp.frame_valid       = rsp_data.frame_valid;
  assign rsp.frame_params      = rsp_data.frame_params;
  assign rsp.mode_valid        = rsp_data.mode_valid;
  assign rsp.mode_value        = rsp_data.mode_value;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------

  // every accepted item yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted item produced no result");

  // a handed-over frame always re-arms the parameter request
  a_frame_requests: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.frame_valid |-> rsp.status[sspi_pkg::ST_REQ])
    else $error("frame handed over without request bit");

  // an interrupt is only raised while busy and requesting
  a_irq_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.interrupt_request |->
      rsp.status[sspi_pkg::ST_BUSY] && rsp.status[sspi_pkg::ST_REQ])
    else $error("interrupt without busy and request");

endmodule

`default_nettype wire

// ===== sim/speech_synth_parameter_interface_top_tb.sv =====
// ============================================================================
// speech_synth_parameter_interface_top_tb - host interface self-checking bench
// Drives host data/mode/command writes, status reads and frame ticks into the
// synthesizer host interface. A predictor built into the bench tracks status,
// frame collection and repeat state and checks every result field.
// Traffic is a short directed pass, then random speech sessions under
// several sender/receiver idle mixes, a long sink hold-off and drain pauses.
// ============================================================================
module speech_synth_parameter_interface_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command field codes the package leaves unnamed: no effect, status only.
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // Command port bytes around the phrase and unknown ranges.
  localparam logic [7:0] OP_PHRASE_FIRST = 8'h00;
  localparam logic [7:0] OP_UNKNOWN_LO   = 8'h05;
  localparam logic [7:0] OP_UNKNOWN_HI   = 8'hFD;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving
  localparam int SINK_HOLD_LEN  = 48;    // long sink stall in the pressure test
  localparam int ITEMS_PER_MIX  = 400;

  logic clk;
  logic rst;

  sspi_in_if  req_if ();
  sspi_out_if rsp_if ();

  speech_synth_parameter_interface_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // 2 ns period, rising edge at 1 ns.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Predicted block state
  // --------------------------------------------------------------------------
  logic [7:0]                   exp_status;
  logic [7:0]                   exp_params [sspi_pkg::FRAME_BYTES];
  logic [sspi_pkg::INDEX_W-1:0] exp_index;
  logic [4:0]                   exp_repeat;
  logic                         exp_frame_ready;
  logic                         exp_running;

  sspi_pkg::result_t pending_reports[$];  // expected results, oldest first

  // Idle knobs, percent of cycles each side sits out.
  int snd_idle_pct;
  int rcv_idle_pct;

  // Sink hold-off request: the test flips hold_toggle, the sink process
  // notices the change and counts the stall itself.
  logic hold_toggle;
  logic hold_seen;
  int   hold_left;

  int items_sent;
  int mismatches;
  int frames_handed;
  int mode_strobes;
  int irqs_seen;
  int quiet_cycles;

  // Stop path: every command write and several tick cases go through here.
  function automatic void stop_speech();
    exp_running     = 1'b0;
    exp_index       = '0;
    exp_repeat      = '0;
    exp_frame_ready = 1'b0;
    exp_status[sspi_pkg::ST_BUSY] = 1'b0;
  endfunction

  // Applies one accepted item to the predicted state and returns the result
  // the block must produce for it.
  function automatic sspi_pkg::result_t next_host_report(sspi_pkg::item_t it);
    sspi_pkg::result_t r;
    int                i;
    r = '0;
    case (it.command)
      sspi_pkg::CMD_DATA: begin
        // Data only lands while the block is busy and asking for parameters.
        if (exp_status[sspi_pkg::ST_BUSY] && exp_status[sspi_pkg::ST_REQ]) begin
          if (exp_repeat == 0 || exp_index != 0) begin
            if (exp_index == 0) exp_repeat = it.value[7:3];
            exp_params[exp_index] = it.value;
            if (exp_index == sspi_pkg::LAST_INDEX) begin
              exp_status[sspi_pkg::ST_REQ] = 1'b0;
              exp_index          = '0;
              if (exp_repeat != 0) exp_repeat--;
              exp_frame_ready    = 1'b1;
            end else begin
              exp_index++;
              r.interrupt_request = 1'b1;
            end
          end else begin
            // Repeat frame: byte 0 kept, 1..5 cleared, the byte goes to 6.
            for (i = 1; i < sspi_pkg::FRAME_BYTES - 1; i++) exp_params[i] = '0;
            exp_params[sspi_pkg::FRAME_BYTES-1] = it.value;
            exp_status[sspi_pkg::ST_REQ] = 1'b0;
            exp_index          = '0;
            exp_repeat--;
            exp_frame_ready    = 1'b1;
          end
        end
      end
      sspi_pkg::CMD_MODE: begin
        r.mode_valid = 1'b1;
        r.mode_value = it.value;
        exp_status   = '0;
      end
      sspi_pkg::CMD_WRITE: begin
        stop_speech();
        if (it.value == sspi_pkg::OP_START) begin
          exp_running         = 1'b1;
          exp_status          = sspi_pkg::STATUS_RUN;
          r.interrupt_request = 1'b1;
        end else if (it.value != sspi_pkg::OP_STOP &&
                     it.value > sspi_pkg::OP_PHRASE_LAST) begin
          exp_status = sspi_pkg::STATUS_ERR;
        end
      end
      sspi_pkg::CMD_TICK: begin
        if (exp_running) begin
          if (!exp_status[sspi_pkg::ST_EXT]) begin
            stop_speech();
          end else if (!exp_frame_ready) begin
            stop_speech();
            exp_status = sspi_pkg::STATUS_ERR;
          end else if (exp_params[0][7:3] == 0) begin
            stop_speech();
          end else begin
            r.frame_valid = 1'b1;
            for (i = 0; i < sspi_pkg::FRAME_BYTES; i++)
              r.frame_params[8*i +: 8] = exp_params[i];
            exp_frame_ready     = 1'b0;
            exp_status[sspi_pkg::ST_REQ] = 1'b1;
            r.interrupt_request = 1'b1;
          end
        end
      end
      default: ;  // status read and spare codes leave the state alone
    endcase
    r.status = exp_status;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Host side: one item per call, entered and left on a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(logic [2:0] cmd, logic [7:0] val);
    sspi_pkg::item_t it;
    it.command = cmd;
    it.value   = val;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.value   <= val;
    do @(posedge clk); while (!req_if.ready);
    pending_reports.push_back(next_host_report(it));
    items_sent++;
    @(negedge clk);
  endtask

  // Input goes quiet until every predicted result has come back.
  task automatic wait_reports_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
  endtask

  // A start followed by a few frames with random content. Full frames or
  // single repeat bytes are picked from the predicted repeat state so most
  // frames reach the synthesizer; some are broken on purpose.
  task automatic send_speech_session();
    int         b;
    logic [7:0] head;
    send_item(sspi_pkg::CMD_WRITE, sspi_pkg::OP_START);
    repeat ($urandom_range(1, 8)) begin
      if (!exp_running) break;
      if (exp_repeat != 0 && $urandom_range(3) != 0) begin
        send_item(sspi_pkg::CMD_DATA, 8'($urandom_range(255)));
      end else begin
        // Mostly a nonzero repeat field; sometimes zero, which ends the run.
        head = ($urandom_range(9) == 0) ? 8'($urandom_range(7))
                                        : 8'($urandom_range(8, 255));
        send_item(sspi_pkg::CMD_DATA, head);
        for (b = 1; b < sspi_pkg::FRAME_BYTES; b++) begin
          if ($urandom_range(19) == 0)
            send_item(sspi_pkg::CMD_STATUS, 8'($urandom_range(255)));
          if ($urandom_range(49) == 0)
            send_item(sspi_pkg::CMD_TICK, 8'($urandom_range(255)));
          send_item(sspi_pkg::CMD_DATA, 8'($urandom_range(255)));
        end
      end
      if ($urandom_range(29) == 0)
        send_item(sspi_pkg::CMD_MODE, 8'($urandom_range(255)));
      send_item(sspi_pkg::CMD_TICK, 8'($urandom_range(255)));
      // A second tick with nothing collected flags an error.
      if ($urandom_range(14) == 0)
        send_item(sspi_pkg::CMD_TICK, 8'($urandom_range(255)));
    end
    if ($urandom_range(1) != 0) send_item(sspi_pkg::CMD_WRITE, sspi_pkg::OP_STOP);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_item(sspi_pkg::CMD_STATUS, 8'hFF);
    send_item(sspi_pkg::CMD_TICK, 8'h00);             // tick while not running
    send_item(sspi_pkg::CMD_DATA, 8'hAA);             // data while idle is dropped
    send_item(sspi_pkg::CMD_WRITE, OP_PHRASE_FIRST);  // phrase command: stop only
    send_item(sspi_pkg::CMD_WRITE, sspi_pkg::OP_START);
    send_item(sspi_pkg::CMD_DATA, 8'hFF);             // repeat field at its maximum
    send_item(sspi_pkg::CMD_DATA, 8'h01);
    send_item(sspi_pkg::CMD_DATA, 8'h80);
    send_item(sspi_pkg::CMD_DATA, 8'h7F);
    send_item(sspi_pkg::CMD_DATA, 8'h55);
    send_item(sspi_pkg::CMD_DATA, 8'hAA);
    send_item(sspi_pkg::CMD_DATA, 8'h00);
    send_item(sspi_pkg::CMD_TICK, 8'hFF);             // full frame handed over
    send_item(sspi_pkg::CMD_DATA, 8'h00);             // single-byte repeat frame
    send_item(sspi_pkg::CMD_TICK, 8'h00);
    send_item(sspi_pkg::CMD_WRITE, sspi_pkg::OP_PHRASE_LAST);
    send_item(sspi_pkg::CMD_WRITE, OP_UNKNOWN_HI);    // unknown command: error only
    send_item(CMD_RSVD5, 8'hFF);
    send_item(CMD_RSVD6, 8'h00);
    send_item(CMD_RSVD7, 8'hFF);
    send_item(sspi_pkg::CMD_WRITE, sspi_pkg::OP_START);
    send_item(sspi_pkg::CMD_TICK, 8'h00);             // nothing collected: error
    send_item(sspi_pkg::CMD_WRITE, sspi_pkg::OP_START);
    send_item(sspi_pkg::CMD_MODE, 8'hFF);             // mode write drops external
    send_item(sspi_pkg::CMD_TICK, 8'h00);             // running without external: stop
    send_item(sspi_pkg::CMD_WRITE, OP_UNKNOWN_LO);
    send_item(sspi_pkg::CMD_MODE, 8'h00);
    send_item(sspi_pkg::CMD_WRITE, sspi_pkg::OP_STOP);
    wait_reports_drained();
  endtask

  task automatic test_random_traffic(int count, int snd_pct, int rcv_pct);
    int target;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 75) send_speech_session();
      else send_item(3'($urandom_range(7)), 8'($urandom_range(255)));  // noise
    end
    wait_reports_drained();
  endtask

  // Sink stalls for a long stretch while the host keeps offering items, so
  // the result register fills and the input stalls behind it.
  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 20;
    repeat (3) begin
      hold_toggle = ~hold_toggle;
      send_speech_session();
      wait_reports_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sink side: random ready with an optional long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = SINK_HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  // Each result taken by the sink is matched against the oldest prediction.
  always @(posedge clk) begin
    sspi_pkg::result_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result with nothing expected, status %0h", rsp_if.status);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("status", want.status, rsp_if.status);
        compare_field("interrupt_request", want.interrupt_request,
                      rsp_if.interrupt_request);
        compare_field("frame_valid", want.frame_valid, rsp_if.frame_valid);
        compare_field("frame_params", want.frame_params, rsp_if.frame_params);
        compare_field("mode_valid", want.mode_valid, rsp_if.mode_valid);
        compare_field("mode_value", want.mode_value, rsp_if.mode_value);
        if (want.frame_valid) frames_handed++;
        if (want.mode_valid) mode_strobes++;
        if (want.interrupt_request) irqs_seen++;
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** speech_synth_parameter_interface_top: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.command = sspi_pkg::CMD_STATUS;
    req_if.value   = '0;
    rsp_if.ready   = 1'b0;
    hold_toggle    = 1'b0;
    hold_seen      = 1'b0;
    hold_left      = 0;
    snd_idle_pct   = 0;
    rcv_idle_pct   = 0;
    items_sent     = 0;
    mismatches     = 0;
    frames_handed  = 0;
    mode_strobes   = 0;
    irqs_seen      = 0;
    quiet_cycles   = 0;
    // Predictor starts from the reset state.
    exp_status      = '0;
    exp_params      = '{default: '0};
    exp_index       = '0;
    exp_repeat      = '0;
    exp_frame_ready = 1'b0;
    exp_running     = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_random_traffic(ITEMS_PER_MIX, 38, 65);
    test_random_traffic(ITEMS_PER_MIX, 65, 38);
    test_backpressure();
    test_random_traffic(ITEMS_PER_MIX, 0, 0);

    // Result path is one register deep; a few spare cycles catch strays.
    repeat (4) @(negedge clk);

    $display("Covered %0d host items: %0d frames handed over, %0d mode strobes,",
             items_sent, frames_handed, mode_strobes);
    $display("%0d parameter interrupts, under mixed idling and long sink stalls.",
             irqs_seen);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("** speech_synth_parameter_interface_top: PASSED **");
    end else begin
      $display("** speech_synth_parameter_interface_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sspi_pkg.sv
rtl/sspi_in_if.sv
rtl/sspi_out_if.sv
rtl/sspi_core.sv
rtl/speech_synth_parameter_interface_top.sv
sim/speech_synth_parameter_interface_top_tb.sv
